// ===== rtl/ptmt_pkg.sv =====
// ----------------------------------------------------------------------------
// ptmt_pkg
// Shared types and constants of the point-in-tetrahedron mesh search.
// ----------------------------------------------------------------------------
`default_nettype none

package ptmt_pkg;

  localparam int MAX_TETRAS = 256;
  localparam int COORD_W    = 20;
  localparam int SLOT_W     = $clog2(MAX_TETRAS);
  localparam int CNT_W      = SLOT_W + 1;
  localparam int ADDR_W     = SLOT_W + 2;
  localparam int VTX_W      = 3 * COORD_W;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int CROSS_W    = PROD_W + 1;
  localparam int DOT_W      = 64;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_WAIT,
    S_EDGE,
    S_CROSS,
    S_DOT,
    S_SUM,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              wr_en;
    logic              q_load;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              edge_en;
    logic              cross_en;
    logic              dot_en;
    logic [1:0]        term;
  } dp_cmd_t;

  // Status from the datapath for the current orientation value.
  typedef struct packed {
    logic pos;
    logic zero;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/ptmt_if.sv =====
// ----------------------------------------------------------------------------
// ptmt_if
// Channel interfaces: input words, result words and configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptmt_in_if
  import ptmt_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [SLOT_W-1:0]         tetra_slot;
  logic [1:0]                corner;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [COORD_W-1:0] coord_z;

  modport source (output valid, func, tetra_slot, corner, coord_x, coord_y, coord_z,
                  input ready);
  modport sink   (input valid, func, tetra_slot, corner, coord_x, coord_y, coord_z,
                  output ready);
endinterface

interface ptmt_out_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic degenerate;

  modport source (output valid, inside_res, degenerate, input ready);
  modport sink   (input valid, inside_res, degenerate, output ready);
endinterface

interface ptmt_cfg_if
  import ptmt_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/ptmt_dp.sv =====
// ----------------------------------------------------------------------------
// ptmt_dp
// Datapath: vertex memory, edge vectors, cross and dot products.
// ----------------------------------------------------------------------------
`default_nettype none

module ptmt_dp
  import ptmt_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire dp_cmd_t                   cmd,
  input  wire logic [SLOT_W-1:0]         in_slot,
  input  wire logic [1:0]                in_corner,
  input  wire logic signed [COORD_W-1:0] in_x,
  input  wire logic signed [COORD_W-1:0] in_y,
  input  wire logic signed [COORD_W-1:0] in_z,
  output dp_stat_t                       stat
);

  logic [VTX_W-1:0] mem [1 << ADDR_W];
  logic [VTX_W-1:0] mem_q_r;
  logic             cap_en_r;
  logic [1:0]       cap_idx_r;

  logic signed [COORD_W-1:0] vtx_r [4][3];
  logic signed [COORD_W-1:0] q_r [3];

  logic signed [DIFF_W-1:0] e01_r [3], e12_r [3], e20_r [3];
  logic signed [DIFF_W-1:0] e03_r [3], e13_r [3], e23_r [3];
  logic signed [DIFF_W-1:0] d0_r [3], d1_r [3], d2_r [3];

  logic signed [DIFF_W-1:0] op_a [3], op_b [3], op_d [3];
  logic signed [DIFF_W-1:0] op_d_r [3];
  logic signed [PROD_W-1:0] prod_r [6];
  logic signed [CROSS_W-1:0] crs [3];
  logic signed [DOT_W-1:0]  dprod_r [3];
  logic signed [DOT_W-1:0]  dsum;
  logic                     negate_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[{in_slot, in_corner}] <= {in_x, in_y, in_z};
    end
    if (cmd.rd_en) begin
      mem_q_r <= mem[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_en_r <= 1'b0;
    end else begin
      cap_en_r <= cmd.rd_en;
    end
    cap_idx_r <= cmd.rd_addr[1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.q_load) begin
      q_r[0] <= in_x;
      q_r[1] <= in_y;
      q_r[2] <= in_z;
    end
    if (cap_en_r) begin
      vtx_r[cap_idx_r][0] <= mem_q_r[3*COORD_W-1:2*COORD_W];
      vtx_r[cap_idx_r][1] <= mem_q_r[2*COORD_W-1:COORD_W];
      vtx_r[cap_idx_r][2] <= mem_q_r[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.edge_en) begin
      for (int i = 0; i < 3; i++) begin
        e01_r[i] <= DIFF_W'(vtx_r[1][i]) - DIFF_W'(vtx_r[0][i]);
        e12_r[i] <= DIFF_W'(vtx_r[2][i]) - DIFF_W'(vtx_r[1][i]);
        e20_r[i] <= DIFF_W'(vtx_r[0][i]) - DIFF_W'(vtx_r[2][i]);
        e03_r[i] <= DIFF_W'(vtx_r[3][i]) - DIFF_W'(vtx_r[0][i]);
        e13_r[i] <= DIFF_W'(vtx_r[3][i]) - DIFF_W'(vtx_r[1][i]);
        e23_r[i] <= DIFF_W'(vtx_r[3][i]) - DIFF_W'(vtx_r[2][i]);
        d0_r[i]  <= DIFF_W'(q_r[i]) - DIFF_W'(vtx_r[0][i]);
        d1_r[i]  <= DIFF_W'(q_r[i]) - DIFF_W'(vtx_r[1][i]);
        d2_r[i]  <= DIFF_W'(q_r[i]) - DIFF_W'(vtx_r[2][i]);
      end
    end
  end

  // Operand choice for the four orientation values.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      unique case (cmd.term)
        2'd0: begin
          op_a[i] = e01_r[i]; op_b[i] = e12_r[i]; op_d[i] = d0_r[i];
        end
        2'd1: begin
          op_a[i] = e01_r[i]; op_b[i] = e13_r[i]; op_d[i] = d0_r[i];
        end
        2'd2: begin
          op_a[i] = e12_r[i]; op_b[i] = e23_r[i]; op_d[i] = d1_r[i];
        end
        default: begin
          op_a[i] = e20_r[i]; op_b[i] = e03_r[i]; op_d[i] = d2_r[i];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cross_en) begin
      prod_r[0] <= op_a[1] * op_b[2];
      prod_r[1] <= op_a[2] * op_b[1];
      prod_r[2] <= op_a[2] * op_b[0];
      prod_r[3] <= op_a[0] * op_b[2];
      prod_r[4] <= op_a[0] * op_b[1];
      prod_r[5] <= op_a[1] * op_b[0];
      for (int i = 0; i < 3; i++) begin
        op_d_r[i] <= op_d[i];
      end
      negate_r <= (cmd.term != 2'd0);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      crs[i] = CROSS_W'(prod_r[2*i]) - CROSS_W'(prod_r[2*i+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dot_en) begin
      for (int i = 0; i < 3; i++) begin
        dprod_r[i] <= DOT_W'(crs[i]) * DOT_W'(op_d_r[i]);
      end
    end
  end

  // The exact value fits in 64 bits, so the wrapped sum is exact.
  assign dsum = dprod_r[0] + dprod_r[1] + dprod_r[2];

  always_comb begin
    stat.zero = (dsum == '0);
    stat.pos  = negate_r ? dsum[DOT_W-1] : (!dsum[DOT_W-1] && !stat.zero);
  end

endmodule

`default_nettype wire

// ===== rtl/ptmt_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptmt_ctrl
// Controller: handshakes, tetrahedron walk and orientation sign checks.
// ----------------------------------------------------------------------------
`default_nettype none

module ptmt_ctrl
  import ptmt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  ptmt_in_if.sink         in_ch,
  ptmt_out_if.source      out_ch,
  ptmt_cfg_if.sink        cfg_ch,
  output dp_cmd_t         cmd,
  input  wire dp_stat_t   stat
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] t_r, t_nxt;
  logic [1:0]       c_r, c_nxt;
  logic [1:0]       k_r, k_nxt;
  logic             prev_r, prev_nxt;
  logic             degen_r, degen_nxt;
  logic             inside_r, inside_nxt;
  logic             ov_r, ov_nxt;
  logic             o_in_r, o_in_nxt;
  logic             o_dg_r, o_dg_nxt;

  logic             in_acc;
  logic             q_acc;
  logic             last_tetra;
  logic             mismatch;
  logic             out_free;
  logic [CNT_W-1:0] n_cap;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign q_acc        = in_acc && (in_ch.func == FUNC_QUERY);
  assign n_cap        = (count_r > CNT_W'(MAX_TETRAS)) ? CNT_W'(MAX_TETRAS) : count_r;
  assign last_tetra   = ((t_r + 1'b1) == n_r);
  assign mismatch     = (k_r != 2'd0) && (stat.pos != prev_r);
  assign out_free     = !ov_r || out_ch.ready;

  assign out_ch.valid      = ov_r;
  assign out_ch.inside_res = o_in_r;
  assign out_ch.degenerate = o_dg_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_acc) begin
          state_nxt = (n_cap == '0) ? S_DONE : S_READ;
        end
      end
      S_READ:  state_nxt = (c_r == 2'd3) ? S_WAIT : S_READ;
      S_WAIT:  state_nxt = S_EDGE;
      S_EDGE:  state_nxt = S_CROSS;
      S_CROSS: state_nxt = S_DOT;
      S_DOT:   state_nxt = S_SUM;
      S_SUM: begin
        priority if (mismatch) begin
          state_nxt = last_tetra ? S_DONE : S_READ;
        end else if (k_r == 2'd3) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_CROSS;
        end
      end
      S_DONE:  state_nxt = out_free ? S_IDLE : S_DONE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd          = '0;
    cmd.wr_en    = in_acc && (in_ch.func == FUNC_LOAD);
    cmd.q_load   = q_acc;
    cmd.rd_addr  = {t_r[SLOT_W-1:0], c_r};
    cmd.term     = k_r;
    unique case (state_r)
      S_READ:  cmd.rd_en    = 1'b1;
      S_EDGE:  cmd.edge_en  = 1'b1;
      S_CROSS: cmd.cross_en = 1'b1;
      S_DOT:   cmd.dot_en   = 1'b1;
      default: ;
    endcase
  end

  // Counters, flags and the output register.
  always_comb begin
    count_nxt  = count_r;
    n_nxt      = n_r;
    t_nxt      = t_r;
    c_nxt      = c_r;
    k_nxt      = k_r;
    prev_nxt   = prev_r;
    degen_nxt  = degen_r;
    inside_nxt = inside_r;
    ov_nxt     = ov_r && !out_ch.ready;
    o_in_nxt   = o_in_r;
    o_dg_nxt   = o_dg_r;

    if (cfg_ch.valid) begin
      count_nxt = cfg_ch.data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (q_acc) begin
          n_nxt      = n_cap;
          t_nxt      = '0;
          c_nxt      = '0;
          k_nxt      = '0;
          degen_nxt  = 1'b0;
          inside_nxt = 1'b0;
        end
      end
      S_READ: c_nxt = c_r + 1'b1;
      S_SUM: begin
        if (stat.zero) begin
          degen_nxt = 1'b1;
        end
        prev_nxt = stat.pos;
        priority if (mismatch) begin
          t_nxt = t_r + 1'b1;
          c_nxt = '0;
          k_nxt = '0;
        end else if (k_r == 2'd3) begin
          inside_nxt = 1'b1;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          ov_nxt   = 1'b1;
          o_in_nxt = inside_r;
          o_dg_nxt = degen_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      ov_r     <= 1'b0;
      degen_r  <= 1'b0;
      inside_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ov_r     <= ov_nxt;
      degen_r  <= degen_nxt;
      inside_r <= inside_nxt;
    end
    n_r    <= n_nxt;
    t_r    <= t_nxt;
    c_r    <= c_nxt;
    k_r    <= k_nxt;
    prev_r <= prev_nxt;
    o_in_r <= o_in_nxt;
    o_dg_r <= o_dg_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/point_in_tetra_mesh_test_top.sv =====
// ----------------------------------------------------------------------------
// point_in_tetra_mesh_test_top
// Point-in-tetrahedron search over a stored mesh of up to 256 tetrahedra.
// ----------------------------------------------------------------------------
// The input channel carries one word per item. A load word (func = 0) writes
// one vertex of one stored tetrahedron as it is accepted and produces no
// result. A query word (func = 1) gives a point, and exactly one result word
// (inside_res, degenerate) follows on the output channel.
// The configuration channel writes tetra_count, the most tetrahedra a query
// walks (values above 256 count as 256); it is always ready and should be
// written while the block is idle.
// A query walks tetrahedra in order. Each one costs four vertex reads from the
// single read port of the vertex memory, a wait state, an edge state and, per
// orientation value, a cross-product, a dot-product and a sign-check state.
// At least two values are evaluated per tetrahedron. One word is worked on
// at a time.
// The result sits in an output register; the next word is accepted while it
// waits. If the receiver stalls when a new result is ready, the block holds it
// internally and takes no word until the output register frees up.
// Reset clears the control state and tetra_count; the vertex memory is not
// cleared, and reading a vertex that was never written gives no defined value.
// ----------------------------------------------------------------------------
`default_nettype none

module point_in_tetra_mesh_test_top
  import ptmt_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  ptmt_in_if.sink    in_ch,
  ptmt_out_if.source out_ch,
  ptmt_cfg_if.sink   cfg_ch
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The controller owns every handshake and the walk over the mesh.
  ptmt_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .cmd    (cmd),
    .stat   (stat)
  );

  // The datapath holds the vertices and the exact orientation arithmetic.
  ptmt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_slot   (in_ch.tetra_slot),
    .in_corner (in_ch.corner),
    .in_x      (in_ch.coord_x),
    .in_y      (in_ch.coord_y),
    .in_z      (in_ch.coord_z),
    .stat      (stat)
  );

endmodule

`default_nettype wire

// ===== rtl/ptmt_chk.sv =====
// ----------------------------------------------------------------------------
// ptmt_chk
// Port checks of the mesh search, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ptmt_chk (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic in_func,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_inside,
  input wire logic out_degen
);

  // A result word stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped before it was taken");

  // A stalled result word keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_inside) && $stable(out_degen))
    else $error("stalled result word changed");

  // A query keeps the input closed on the following cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_func |=> !in_ready)
    else $error("word accepted while a query is being searched");

  // Reset leaves no result word offered.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word offered right after reset");

endmodule

bind point_in_tetra_mesh_test_top ptmt_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_func    (in_ch.func),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_inside (out_ch.inside_res),
  .out_degen  (out_ch.degenerate)
);

`default_nettype wire

// ===== bench/tb_point_in_tetra_mesh_test_top.sv =====
// ----------------------------------------------------------------------------
// tb_point_in_tetra_mesh_test_top
// Self-checking bench for the point-in-tetrahedron mesh search.
// ----------------------------------------------------------------------------
// Vertex loads and point queries go in as words on the input channel, and
// every accepted query word is run through a bit-exact orientation predictor
// kept in the bench. The verdict words that come back are compared against
// the queued predictions in order. Directed cases cover an empty mesh,
// boundary points, extreme coordinates and flat tetrahedra. Random phases
// rebuild small meshes around random centers and probe near them. The last
// phase sets the count at and above full capacity and probes a point inside
// the first tetrahedron, where the walk ends.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_point_in_tetra_mesh_test_top;
  import ptmt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_MAX   = (1 << (COORD_W - 1)) - 1;
  localparam int COORD_MIN   = -(1 << (COORD_W - 1));
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int HOLD_CYCLES = 2500;
  localparam int RANDOM_ITEMS = 440;

  // One vertex or offset, held at full 64-bit width so that the orientation
  // arithmetic wraps exactly as the hardware's does.
  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
  } vec3_t;

  typedef struct {
    bit hit;
    bit degen;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ptmt_in_if  in_ch ();
  ptmt_out_if out_ch ();
  ptmt_cfg_if cfg_ch ();

  point_in_tetra_mesh_test_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  always #4 clk = ~clk;

  // Mirror of the block's state: the vertex memory, which entries hold a
  // written vertex, and the search count.
  vec3_t            mesh_vertex [MAX_TETRAS*4];
  bit               mesh_written [MAX_TETRAS*4];
  logic [CNT_W-1:0] search_count;

  verdict_t pending_verdicts [$];
  int       error_count = 0;
  int       cycle_count = 0;
  int       burst_left = 0;
  int       random_items = 0;

  // The long receiver hold-off is requested by a test and counted down here.
  bit hold_req = 1'b0;
  bit hold_off = 1'b0;
  int stall_mode = 0;
  int stall_left = 0;

  task automatic report(input string what, input int got, input int want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // ----- Predictor ---------------------------------------------------------

  function automatic vec3_t vsub(input vec3_t a, input vec3_t b);
    vec3_t r;
    r.x = a.x - b.x;
    r.y = a.y - b.y;
    r.z = a.z - b.z;
    return r;
  endfunction

  function automatic vec3_t vcross(input vec3_t a, input vec3_t b);
    vec3_t r;
    r.x = a.y * b.z - a.z * b.y;
    r.y = a.z * b.x - a.x * b.z;
    r.z = a.x * b.y - a.y * b.x;
    return r;
  endfunction

  function automatic logic signed [63:0] vdot(input vec3_t a, input vec3_t b);
    return a.x * b.x + a.y * b.y + a.z * b.z;
  endfunction

  // A zero value is not positive and marks the query as degenerate.
  function automatic bit positive(input logic signed [63:0] v, inout bit degen);
    if (v == 0) begin
      degen = 1'b1;
      return 1'b0;
    end
    return !v[63];
  endfunction

  function automatic verdict_t locate_point(input vec3_t p);
    verdict_t         v;
    int               n;
    vec3_t            p0, p1, p2, p3, e01, e12, e20, e03, e13, e23, d0;
    bit               s1, s2, s3, s4;
    v.hit   = 1'b0;
    v.degen = 1'b0;
    n = (search_count > MAX_TETRAS) ? MAX_TETRAS : int'(search_count);
    for (int t = 0; t < n && !v.hit; t++) begin
      p0 = mesh_vertex[t*4 + 0];
      p1 = mesh_vertex[t*4 + 1];
      p2 = mesh_vertex[t*4 + 2];
      p3 = mesh_vertex[t*4 + 3];
      e01 = vsub(p1, p0);
      e12 = vsub(p2, p1);
      e20 = vsub(p0, p2);
      e03 = vsub(p3, p0);
      e13 = vsub(p3, p1);
      e23 = vsub(p3, p2);
      d0  = vsub(p, p0);
      s1 = positive(vdot(d0, vcross(e01, e12)), v.degen);
      s2 = positive(-vdot(d0, vcross(e01, e13)), v.degen);
      if (s1 != s2) continue;
      s3 = positive(-vdot(vsub(p, p1), vcross(e12, e23)), v.degen);
      if (s2 != s3) continue;
      s4 = positive(-vdot(vsub(p, p2), vcross(e20, e03)), v.degen);
      if (s3 != s4) continue;
      v.hit = 1'b1;
    end
    return v;
  endfunction

  // ----- Sender ------------------------------------------------------------

  // Sends one word and updates the predictor at the edge where it is taken.
  // Valid stays high after acceptance so that bursts run back to back.
  task automatic send_word(input logic func, input int slot, input int corner,
                           input int x, input int y, input int z);
    vec3_t p;
    int    gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= func;
    in_ch.tetra_slot <= SLOT_W'(slot);
    in_ch.corner     <= 2'(corner);
    in_ch.coord_x    <= COORD_W'(x);
    in_ch.coord_y    <= COORD_W'(y);
    in_ch.coord_z    <= COORD_W'(z);
    do @(posedge clk); while (!in_ch.ready);
    p.x = x;
    p.y = y;
    p.z = z;
    if (func == FUNC_LOAD) begin
      mesh_vertex[slot*4 + corner]  = p;
      mesh_written[slot*4 + corner] = 1'b1;
    end else begin
      pending_verdicts.insert(pending_verdicts.size(), locate_point(p));
    end
    @(negedge clk);
    burst_left--;
  endtask

  task automatic query(input int x, input int y, input int z);
    send_word(FUNC_QUERY, $urandom_range(0, 255), $urandom_range(0, 3), x, y, z);
  endtask

  function automatic int clamp_coord(input int v);
    return (v > COORD_MAX) ? COORD_MAX : (v < COORD_MIN) ? COORD_MIN : v;
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(0, 2*COORD_MAX + 1)) + COORD_MIN;
  endfunction

  function automatic int jitter(input int c, input int r);
    return clamp_coord(c + int'($urandom_range(0, 2*r)) - r);
  endfunction

  // Writes the four corners of one tetrahedron scattered around a center.
  task automatic load_tetra(input int slot, input int cx, input int cy, input int cz,
                            input int r);
    for (int c = 0; c < 4; c++)
      send_word(FUNC_LOAD, slot, c, jitter(cx, r), jitter(cy, r), jitter(cz, r));
  endtask

  task automatic load_random_tetra(input int slot);
    int r;
    r = ($urandom_range(0, 3) == 0) ? 2 : $urandom_range(16, 200000);
    load_tetra(slot, rand_coord(), rand_coord(), rand_coord(), r);
  endtask

  // Any slot a query will read must hold four written corners first.
  task automatic fill_unwritten(input int n);
    for (int s = 0; s < n; s++)
      if (!(mesh_written[s*4] && mesh_written[s*4+1] && mesh_written[s*4+2]
            && mesh_written[s*4+3]))
        load_random_tetra(s);
  endtask

  // Drops valid, waits for every expected verdict and lets a load that is
  // still being written settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_search_count(input int n);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= CNT_W'(n);
    do @(posedge clk); while (!cfg_ch.ready);
    search_count = CNT_W'(n);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // ----- Receiver ----------------------------------------------------------

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(16, 200);
    end
    stall_left--;
    case (stall_mode)
      0: out_ch.ready <= !hold_off;
      1: out_ch.ready <= !hold_off && $urandom_range(0, 1);
      default: out_ch.ready <= !hold_off && ($urandom_range(0, 7) == 0);
    endcase
  end

  always begin
    wait (hold_req);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_off = 1'b0;
    hold_req = 1'b0;
  end

  // Every verdict word is checked against the oldest prediction.
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_verdicts.size() == 0) begin
        report("unexpected verdict word, inside_res", out_ch.inside_res, -1);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_ch.inside_res !== want.hit)
          report("inside_res", out_ch.inside_res, want.hit);
        if (out_ch.degenerate !== want.degen)
          report("degenerate", out_ch.degenerate, want.degen);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // ----- Tests -------------------------------------------------------------

  // With the count at its reset value of zero, a query finds nothing.
  task automatic test_empty_mesh();
    query(0, 0, 0);
    query(COORD_MAX, COORD_MIN, 1);
  endtask

  // A unit tetrahedron, a huge one spanning the coordinate range and a flat
  // one collapsed to a point, probed inside, outside, on a vertex and at the
  // coordinate extremes.
  task automatic test_directed_cases();
    load_tetra(0, 0, 0, 0, 0);
    send_word(FUNC_LOAD, 0, 1, 1024, 0, 0);
    send_word(FUNC_LOAD, 0, 2, 0, 1024, 0);
    send_word(FUNC_LOAD, 0, 3, 0, 0, 1024);
    set_search_count(1);
    query(100, 100, 100);
    query(-100, 100, 100);
    query(0, 0, 0);
    query(2000, 2000, 2000);
    query(COORD_MAX, COORD_MAX, COORD_MAX);
    send_word(FUNC_LOAD, 1, 0, COORD_MIN, COORD_MIN, COORD_MIN);
    send_word(FUNC_LOAD, 1, 1, COORD_MAX, COORD_MIN, COORD_MIN);
    send_word(FUNC_LOAD, 1, 2, COORD_MIN, COORD_MAX, COORD_MIN);
    send_word(FUNC_LOAD, 1, 3, COORD_MIN, COORD_MIN, COORD_MAX);
    load_tetra(2, 5000, -5000, 7, 0);
    set_search_count(3);
    query(-500000, -500000, -500000);
    query(COORD_MIN, COORD_MIN, COORD_MIN);
    query(COORD_MAX, COORD_MAX, COORD_MAX);
    send_word(FUNC_LOAD, 255, 3, COORD_MAX, COORD_MIN, -1);
    set_search_count(0);
    query(100, 100, 100);
  endtask

  // Phases with a small random count: most items rebuild a tetrahedron and
  // probe near its center, the rest are stray loads and random queries.
  task automatic test_random_mesh();
    int n, s, cx, cy, cz, r;
    while (random_items < RANDOM_ITEMS) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
      fill_unwritten(n);
      set_search_count(n);
      repeat ($urandom_range(4, 10)) begin
        case ($urandom_range(0, 7))
          6: begin
            send_word(FUNC_LOAD, $urandom_range(0, 255), $urandom_range(0, 3),
                      rand_coord(), rand_coord(), rand_coord());
            random_items++;
          end
          7: begin
            query(rand_coord(), rand_coord(), rand_coord());
            random_items++;
          end
          default: begin
            s  = $urandom_range(0, n - 1);
            r  = ($urandom_range(0, 4) == 0) ? 2 : $urandom_range(16, 200000);
            cx = rand_coord();
            cy = rand_coord();
            cz = rand_coord();
            load_tetra(s, cx, cy, cz, r);
            query(jitter(cx, r / 3), jitter(cy, r / 3), jitter(cz, r / 3));
            query(jitter(cx, 2 * r), jitter(cy, 2 * r), jitter(cz, 2 * r));
            random_items += 6;
          end
        endcase
      end
    end
  endtask

  // The receiver holds off for a long stretch while queries keep coming, so
  // the block fills and stalls its input. Then the sender pauses until
  // every verdict is back.
  task automatic test_backpressure();
    fill_unwritten(4);
    set_search_count(4);
    hold_req = 1'b1;
    @(negedge clk);
    repeat (8) query(rand_coord(), rand_coord(), rand_coord());
    drain();
    repeat (6) query(rand_coord(), rand_coord(), rand_coord());
    drain();
  endtask

  // Counts at capacity and above it. Each point lies inside the unit
  // tetrahedron in the first slot, so the walk ends there.
  task automatic test_full_capacity();
    send_word(FUNC_LOAD, 0, 0, 0, 0, 0);
    send_word(FUNC_LOAD, 0, 1, 1024, 0, 0);
    send_word(FUNC_LOAD, 0, 2, 0, 1024, 0);
    send_word(FUNC_LOAD, 0, 3, 0, 0, 1024);
    set_search_count(MAX_TETRAS);
    query(100, 100, 100);
    set_search_count(MAX_TETRAS + 1);
    query(200, 150, 100);
    set_search_count((1 << CNT_W) - 1);
    query(300, 200, 100);
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.func       = FUNC_LOAD;
    in_ch.tetra_slot = '0;
    in_ch.corner     = '0;
    in_ch.coord_x    = '0;
    in_ch.coord_y    = '0;
    in_ch.coord_z    = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.data      = '0;
    out_ch.ready     = 1'b0;
    search_count     = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_mesh();
    test_directed_cases();
    test_random_mesh();
    test_backpressure();
    test_full_capacity();

    drain();
    repeat (50) @(negedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/ptmt_pkg.sv
rtl/ptmt_if.sv
rtl/ptmt_dp.sv
rtl/ptmt_ctrl.sv
rtl/point_in_tetra_mesh_test_top.sv
rtl/ptmt_chk.sv
bench/tb_point_in_tetra_mesh_test_top.sv
